// File: hw/rtl/b64d_pkg.sv
// b64d_pkg: types, constants and the character classifier of the base64 stream decoder
// no dependencies; imported by every module of the block
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS = 6'd62;
  localparam logic [5:0] SX_SLASH = 6'd63;
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       message_done;
  } res_item_t;

  typedef struct packed {
    logic [1:0]            n;
    res_item_t [2:0]       res;
  } burst_t;

  typedef struct packed {
    logic       is_alpha;
    logic       is_pad;
    logic [5:0] sextet;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    logic [7:0]  d;
    r = '0;
    d = '0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A;
      r.is_alpha = 1'b1;
      r.sextet = d[5:0];
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A;
      r.is_alpha = 1'b1;
      r.sextet = d[5:0] + SX_LOWER_BASE;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0;
      r.is_alpha = 1'b1;
      r.sextet = d[5:0] + SX_DIGIT_BASE;
    end else if (c == CH_PLUS) begin
      r.is_alpha = 1'b1;
      r.sextet = SX_PLUS;
    end else if (c == CH_SLASH) begin
      r.is_alpha = 1'b1;
      r.sextet = SX_SLASH;
    end else if (c == PAD_CHAR) begin
      r.is_pad = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b64d_stream_if.sv
// b64d_stream_if: valid/ready channel carrying one payload beat
// payload type is supplied by the user, normally from b64d_pkg
`default_nettype none

interface b64d_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/b64d_group_decode.sv
// b64d_group_decode: group state registers and the decode of one accepted character
// depends on b64d_pkg; produces a burst of up to three results per beat
`default_nettype none

module b64d_group_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire b64d_pkg::in_item_t item,
  output b64d_pkg::burst_t       burst
);
  import b64d_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  logic       stopped_r, stopped_nxt;
  logic [5:0] sx_r [3];
  logic       pm_r [3];
  logic       hold_we;

  char_class_t cc;
  logic        counts;
  logic [7:0]  b0, b1, b2;
  logic [1:0]  n;
  res_item_t [2:0] res;

  always_comb begin
    cc = classify(item.ch);
    counts = accept && !stopped_r && (cc.is_alpha || cc.is_pad);
    b0 = {sx_r[0], sx_r[1][5:4]};
    b1 = {sx_r[1][3:0], sx_r[2][5:2]};
    b2 = {sx_r[2][1:0], cc.sextet};
    hold_we = 1'b0;
    cnt_nxt = cnt_r;
    stopped_nxt = stopped_r;
    n = 2'd0;
    res = '0;
    res[0].data_byte = b0;
    res[1].data_byte = b1;
    res[2].data_byte = b2;
    if (counts) begin
      if (cnt_r != 2'd3) begin
        hold_we = 1'b1;
        cnt_nxt = cnt_r + 2'd1;
      end else begin
        cnt_nxt = 2'd0;
        if (!pm_r[0] && !pm_r[1] && !pm_r[2] && !cc.is_pad) begin
          n = 2'd3;
        end else if (!pm_r[0] && !pm_r[1] && !pm_r[2] && cc.is_pad) begin
          n = 2'd2;
          stopped_nxt = 1'b1;
        end else if (!pm_r[0] && !pm_r[1] && pm_r[2] && cc.is_pad) begin
          n = 2'd1;
          stopped_nxt = 1'b1;
        end
      end
    end
    res[0].byte_valid = 1'b1;
    res[1].byte_valid = 1'b1;
    res[2].byte_valid = 1'b1;
    if (accept && item.end_of_message) begin
      cnt_nxt = 2'd0;
      stopped_nxt = 1'b0;
      if (n == 2'd0) begin
        n = 2'd1;
        res[0].data_byte = '0;
        res[0].byte_valid = 1'b0;
      end
    end
    case (n)
      2'd1: begin
        res[0].last_of_run = 1'b1;
        res[0].message_done = item.end_of_message;
      end
      2'd2: begin
        res[1].last_of_run = 1'b1;
        res[1].message_done = item.end_of_message;
      end
      2'd3: begin
        res[2].last_of_run = 1'b1;
        res[2].message_done = item.end_of_message;
      end
      default: begin
      end
    endcase
    burst.n = n;
    burst.res = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      stopped_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_we) begin
      sx_r[cnt_r] <= cc.is_pad ? 6'd0 : cc.sextet;
      pm_r[cnt_r] <= cc.is_pad;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b64d_result_fifo.sv
// b64d_result_fifo: result queue taking up to three results a cycle, giving one a cycle when popped
// depends on b64d_pkg; the depth must be a power of two, at least four; the block does not enforce this
`default_nettype none

module b64d_result_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire b64d_pkg::burst_t    push,
  input  wire logic                pop,
  output b64d_pkg::res_item_t      head,
  output logic                     not_empty,
  output logic                     room
);
  import b64d_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  res_item_t         mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt = count_r + CNT_W'(push.n) - CNT_W'(pop);
    head = mem_r[rd_ptr_r];
    not_empty = (count_r != '0);
    room = (count_r <= CNT_W'(DEPTH - MAX_RESULTS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push.n) begin
        mem_r[PTR_W'(wr_ptr_r + PTR_W'(i))] <= push.res[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/base64_stream_decoder.sv
// base64_stream_decoder: top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_stream_if, b64d_group_decode, b64d_result_fifo
//
// usage
// in_s takes one encoded character per beat (ch, end_of_message); out_s gives
// one decoded byte per beat with byte_valid, last_of_run and message_done.
// a beat that completes a group of four yields up to three output beats; the
// end-of-message beat always yields at least one (an empty marker if needed).
// results of an input beat appear on out_s the cycle after it is taken if the
// result queue was empty. one input beat per cycle while in_s.ready is high,
// one output beat per cycle while out_s.ready is high; a full group gives three
// bytes per four characters, so the stream keeps pace. the result queue
// (FIFO_DEPTH entries) decouples the two sides: in_s.ready stays high while at
// least three entries are free, so with a stalled receiver input stops once fewer remain.
// reset (rst_n low, synchronous) empties the queue and clears the group count
// and the stopped flag; held sextets need no reset.
`default_nettype none

module base64_stream_decoder #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  b64d_stream_if.sink    in_s,
  b64d_stream_if.source  out_s
);
  import b64d_pkg::*;

  logic      in_accept;
  logic      fifo_room;
  logic      fifo_not_empty;
  burst_t    burst;
  res_item_t head;

  assign in_s.ready = fifo_room;
  assign in_accept = in_s.valid && fifo_room;

  b64d_group_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_s.data),
    .burst  (burst)
  );

  b64d_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (burst),
    .pop       (out_s.ready && fifo_not_empty),
    .head      (head),
    .not_empty (fifo_not_empty),
    .room      (fifo_room)
  );

  assign out_s.valid = fifo_not_empty;
  assign out_s.data = head;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for base64_stream_decoder, directed and random character streams
// depends on b64d_pkg, b64d_stream_if and the decoder rtl; predicts bytes per beat and compares
// every output beat in order, under several idle and stall mixes on both channels
`default_nettype none

module tb_top;
  import b64d_pkg::*;

  typedef struct packed {
    logic       alpha;
    logic       pad;
    logic [5:0] value;
  } sym_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  b64d_stream_if #(.payload_t(in_item_t))  in_if ();
  b64d_stream_if #(.payload_t(res_item_t)) out_if ();

  base64_stream_decoder u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if)
  );

  always #4 clk = ~clk;

  in_item_t   char_queue[$];
  res_item_t  exp_bytes[$];
  logic [7:0] msg_buf[$];
  int         items_total = 0;
  int         beats_in = 0;
  int         mismatch_cnt = 0;
  int         idle_in_pct = 0;
  int         stall_out_pct = 0;

  // decoder state as predicted
  int         grp_cnt = 0;
  logic [5:0] grp_sx[3];
  logic       grp_pad[3];
  logic       halted = 1'b0;

  res_item_t  got_r;
  res_item_t  want_r;

  function automatic sym_t char_to_sym(input logic [7:0] c);
    sym_t s;
    s = '0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      s.alpha = 1'b1;
      s.value = 6'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      s.alpha = 1'b1;
      s.value = 6'(c - CH_LOWER_A) + SX_LOWER_BASE;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      s.alpha = 1'b1;
      s.value = 6'(c - CH_DIGIT_0) + SX_DIGIT_BASE;
    end else if (c == CH_PLUS) begin
      s.alpha = 1'b1;
      s.value = SX_PLUS;
    end else if (c == CH_SLASH) begin
      s.alpha = 1'b1;
      s.value = SX_SLASH;
    end else if (c == PAD_CHAR) begin
      s.pad = 1'b1;
    end
    return s;
  endfunction

  function automatic res_item_t byte_res(input logic [7:0] b);
    res_item_t r;
    r = '0;
    r.data_byte = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  task automatic predict_beat(input in_item_t beat);
    sym_t       s;
    res_item_t  run[$];
    logic [5:0] sx;
    logic [7:0] b0, b1, b2;
    s = char_to_sym(beat.ch);
    sx = s.pad ? 6'd0 : s.value;
    if (!halted && (s.alpha || s.pad)) begin
      if (grp_cnt < 3) begin
        grp_sx[grp_cnt] = sx;
        grp_pad[grp_cnt] = s.pad;
        grp_cnt++;
      end else begin
        b0 = {grp_sx[0], grp_sx[1][5:4]};
        b1 = {grp_sx[1][3:0], grp_sx[2][5:2]};
        b2 = {grp_sx[2][1:0], sx};
        if (!grp_pad[0] && !grp_pad[1]) begin
          if (!grp_pad[2]) begin
            run.push_back(byte_res(b0));
            run.push_back(byte_res(b1));
            if (!s.pad) run.push_back(byte_res(b2));
            else halted = 1'b1;
          end else if (s.pad) begin
            run.push_back(byte_res(b0));
            halted = 1'b1;
          end
        end
        grp_cnt = 0;
      end
    end
    if (beat.end_of_message) begin
      if (run.size() == 0) run.push_back(res_item_t'('0));
      run[run.size()-1].message_done = 1'b1;
      grp_cnt = 0;
      halted = 1'b0;
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) exp_bytes.push_back(run[i]);
  endtask

  task automatic push_item(input logic [7:0] c, input logic eom);
    in_item_t it;
    it.ch = c;
    it.end_of_message = eom;
    char_queue.push_back(it);
    items_total++;
  endtask

  task automatic push_text(input string s, input logic eom_last);
    for (int i = 0; i < s.len(); i++) push_item(s[i], eom_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_b64_char();
    int v;
    v = $urandom_range(63);
    if (v < 26) return CH_UPPER_A + 8'(v);
    if (v < 52) return CH_LOWER_A + 8'(v - 26);
    if (v < 62) return CH_DIGIT_0 + 8'(v - 52);
    return (v == 62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [7:0] rand_noise_char();
    logic [7:0] c;
    sym_t       s;
    do begin
      c = 8'($urandom_range(255));
      s = char_to_sym(c);
    end while (s.alpha || s.pad);
    return c;
  endfunction

  task automatic add_sym(input logic [7:0] c);
    if ($urandom_range(99) < 10) msg_buf.push_back(rand_noise_char());
    msg_buf.push_back(c);
  endtask

  task automatic add_group(input int pads);
    for (int i = 0; i < 4; i++) add_sym((i >= 4 - pads) ? PAD_CHAR : rand_b64_char());
  endtask

  task automatic add_bad_group();
    logic [7:0] g[4];
    int         p;
    for (int i = 0; i < 4; i++) g[i] = rand_b64_char();
    p = $urandom_range(2);
    g[p] = PAD_CHAR;
    if (p < 2 && $urandom_range(1)) g[3] = PAD_CHAR;
    for (int i = 0; i < 4; i++) add_sym(g[i]);
  endtask

  task automatic flush_msg();
    for (int i = 0; i < msg_buf.size(); i++) push_item(msg_buf[i], i == msg_buf.size() - 1);
    msg_buf.delete();
  endtask

  task automatic gen_message();
    int kind;
    int ngroups;
    kind = $urandom_range(99);
    ngroups = $urandom_range(3);
    if (kind < 60) begin
      for (int i = 0; i < ngroups; i++) add_group(0);
      add_group($urandom_range(2));
      if ($urandom_range(3) == 0) begin
        for (int i = 0; i < $urandom_range(1, 3); i++)
          add_sym($urandom_range(3) == 0 ? PAD_CHAR : rand_b64_char());
      end
    end else if (kind < 75) begin
      for (int i = 0; i < ngroups; i++) add_group(0);
      for (int i = 0; i < $urandom_range(1, 3); i++) add_sym(rand_b64_char());
    end else if (kind < 90) begin
      if (ngroups > 1) add_group(0);
      add_bad_group();
      add_group($urandom_range(2));
    end else begin
      for (int i = 0; i < $urandom_range(1, 8); i++)
        msg_buf.push_back($urandom_range(4) == 0 ? PAD_CHAR : 8'($urandom_range(255)));
    end
    if ($urandom_range(9) == 0) msg_buf.push_back(rand_noise_char());
    flush_msg();
  endtask

  task automatic wait_drained();
    while (beats_in != items_total || exp_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: mismatch %s expected %0h actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_beat(in_if.data);
        beats_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (char_queue.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
          in_if.valid <= 1'b1;
          in_if.data <= char_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_r = out_if.data;
        if (exp_bytes.size() == 0) begin
          $display("%0t: unexpected beat expected none actual %0h/%b/%b/%b", $time,
                   got_r.data_byte, got_r.byte_valid, got_r.last_of_run, got_r.message_done);
          mismatch_cnt++;
        end else begin
          want_r = exp_bytes.pop_front();
          check_field("data_byte", want_r.data_byte, got_r.data_byte);
          check_field("byte_valid", 8'(want_r.byte_valid), 8'(got_r.byte_valid));
          check_field("last_of_run", 8'(want_r.last_of_run), 8'(got_r.last_of_run));
          check_field("message_done", 8'(want_r.message_done), 8'(got_r.message_done));
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_out_pct);
    end
  end

  initial begin
    int target;
    int guard;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    push_text("+/z9", 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_text("=AAA", 1'b1);
    push_text("AB=C", 1'b0);
    push_text("TQ==", 1'b0);
    push_text("Z", 1'b1);
    push_text("TWE=", 1'b1);
    push_text("Zm", 1'b1);
    push_item(8'h80, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 74; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 74; end
        default: begin idle_in_pct = 6; stall_out_pct = 6; end
      endcase
      target = items_total + 46;
      while (items_total < target) gen_message();
      wait_drained();
    end

    guard = 0;
    while ((beats_in != items_total || exp_bytes.size() != 0) && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
    if (exp_bytes.size() != 0) begin
      $display("%0t: %0d beats expected but never seen", $time, exp_bytes.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("** base64_stream_decoder: PASSED **");
    end else begin
      $display("** base64_stream_decoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** base64_stream_decoder: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
